/* rtl/core/md5_pkg.sv */
package md5_pkg;

    // one input item: a message word and its block flags
    typedef struct packed {
        logic [31:0] msg_word;
        logic        first_block;
        logic        last_block;
    } msg_item_t;

    // one result item: a digest word and its position
    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  digest_index;
        logic        digest_last;
    } digest_item_t;

    // controller states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PREP,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } md5_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       load_en;
        logic [3:0] load_idx;
        logic       init_chain;
        logic       prep;
        logic       round_en;
        logic [5:0] round_idx;
        logic       add_chain;
        logic [1:0] out_idx;
    } md5_cmd_t;

    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [3:0] LAST_WORD  = 4'd15;
    localparam logic [1:0] LAST_DIGEST = 2'd3;

    // initial chaining values a0..d0
    localparam logic [31:0] INIT_VECTOR [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    // additive round constants
    localparam logic [31:0] ROUND_CONST [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // rotation amounts by round group and position
    localparam logic [4:0] ROT_AMOUNT [16] = '{
        5'd7,  5'd12, 5'd17, 5'd22,
        5'd5,  5'd9,  5'd14, 5'd20,
        5'd4,  5'd11, 5'd16, 5'd23,
        5'd6,  5'd10, 5'd15, 5'd21
    };

    // message word index used by a round
    function automatic logic [3:0] word_index(input logic [5:0] rnd);
        logic [3:0] x;
        logic [3:0] g;
        begin
            x = rnd[3:0];
            case (rnd[5:4])
                2'd0:    g = x;
                2'd1:    g = x * 4'd5 + 4'd1;
                2'd2:    g = x * 4'd3 + 4'd5;
                default: g = x * 4'd7;
            endcase
            return g;
        end
    endfunction

    // round function by group
    function automatic logic [31:0] round_func(input logic [1:0] grp, input logic [31:0] b,
                                              input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            case (grp)
                2'd0:    f = (b & c) | (~b & d);
                2'd1:    f = (d & b) | (~d & c);
                2'd2:    f = b ^ c ^ d;
                default: f = c ^ (b | ~d);
            endcase
            return f;
        end
    endfunction

    // left rotate by a variable amount
    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        begin
            t = {x, x} << n;
            return t[63:32];
        end
    endfunction

endpackage

/* rtl/core/md5_ctrl.sv */
module md5_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msg_valid,
    input  logic                first_block,
    input  logic                last_block,
    output logic                msg_ready,
    output logic                digest_valid,
    input  logic                digest_ready,
    output md5_pkg::md5_cmd_t   cmd
);

    md5_pkg::md5_state_t state_reg, state_next;
    logic [3:0] word_cnt_reg, word_cnt_next;
    logic [5:0] round_reg, round_next;
    logic [1:0] out_idx_reg, out_idx_next;
    logic       last_reg, last_next;
    logic       msg_acc;
    logic       digest_acc;

    assign msg_acc    = msg_valid && (state_reg == md5_pkg::ST_LOAD);
    assign digest_acc = digest_ready && (state_reg == md5_pkg::ST_OUT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            md5_pkg::ST_LOAD:
            begin
                if (msg_acc && word_cnt_reg == md5_pkg::LAST_WORD)
                    state_next = md5_pkg::ST_PREP;
            end
            md5_pkg::ST_PREP:
                state_next = md5_pkg::ST_ROUND;
            md5_pkg::ST_ROUND:
            begin
                if (round_reg == md5_pkg::LAST_ROUND)
                    state_next = md5_pkg::ST_ADD;
            end
            md5_pkg::ST_ADD:
                state_next = last_reg ? md5_pkg::ST_OUT : md5_pkg::ST_LOAD;
            md5_pkg::ST_OUT:
            begin
                if (digest_acc && out_idx_reg == md5_pkg::LAST_DIGEST)
                    state_next = md5_pkg::ST_LOAD;
            end
            default:
                state_next = md5_pkg::ST_LOAD;
        endcase
    end

    // counters and block flag
    always_comb
    begin
        word_cnt_next = word_cnt_reg;
        round_next    = round_reg;
        out_idx_next  = out_idx_reg;
        last_next     = last_reg;
        if (msg_acc)
        begin
            word_cnt_next = word_cnt_reg + 4'd1;
            if (word_cnt_reg == md5_pkg::LAST_WORD)
                last_next = last_block;
        end
        if (state_reg == md5_pkg::ST_PREP)
            round_next = '0;
        else if (state_reg == md5_pkg::ST_ROUND)
            round_next = round_reg + 6'd1;
        if (state_reg == md5_pkg::ST_ADD)
            out_idx_next = '0;
        else if (digest_acc)
            out_idx_next = out_idx_reg + 2'd1;
    end

    // outputs
    always_comb
    begin
        msg_ready      = (state_reg == md5_pkg::ST_LOAD);
        digest_valid   = (state_reg == md5_pkg::ST_OUT);
        cmd.load_en    = msg_acc;
        cmd.load_idx   = word_cnt_reg;
        cmd.init_chain = msg_acc && (word_cnt_reg == 4'd0) && first_block;
        cmd.prep       = (state_reg == md5_pkg::ST_PREP);
        cmd.round_en   = (state_reg == md5_pkg::ST_ROUND);
        cmd.round_idx  = round_reg;
        cmd.add_chain  = (state_reg == md5_pkg::ST_ADD);
        cmd.out_idx    = out_idx_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= md5_pkg::ST_LOAD;
            word_cnt_reg <= '0;
            round_reg    <= '0;
            out_idx_reg  <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            word_cnt_reg <= word_cnt_next;
            round_reg    <= round_next;
            out_idx_reg  <= out_idx_next;
            last_reg     <= last_next;
        end
    end

endmodule

/* rtl/core/md5_datapath.sv */
module md5_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  md5_pkg::md5_cmd_t       cmd,
    input  logic [31:0]             msg_word,
    output md5_pkg::digest_item_t   digest
);

    logic [31:0] words_reg [16];
    logic [31:0] chain_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] pre_reg, pre_next;
    logic [31:0] f_val;
    logic [31:0] sum_val;
    logic [31:0] new_b;
    logic [5:0]  next_round;

    // block word store
    always_ff @(posedge clk)
    begin
        if (cmd.load_en)
            words_reg[cmd.load_idx] <= msg_word;
    end

    // one round: f plus the preadded a, k and m, rotate, add b
    assign f_val      = md5_pkg::round_func(cmd.round_idx[5:4], b_reg, c_reg, d_reg);
    assign sum_val    = f_val + pre_reg;
    assign new_b      = b_reg + md5_pkg::rotl32(sum_val, md5_pkg::ROT_AMOUNT[{cmd.round_idx[5:4],
                                                                         cmd.round_idx[1:0]}]);
    assign next_round = cmd.round_idx + 6'd1;

    // preadd for the following round: its a is the current d, or chaining value a0 on prep
    always_comb
    begin
        if (cmd.prep)
            pre_next = chain_reg[0] + md5_pkg::ROUND_CONST[0]
                       + words_reg[md5_pkg::word_index(6'd0)];
        else
            pre_next = d_reg + md5_pkg::ROUND_CONST[next_round]
                       + words_reg[md5_pkg::word_index(next_round)];
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            a_reg   <= chain_reg[0];
            b_reg   <= chain_reg[1];
            c_reg   <= chain_reg[2];
            d_reg   <= chain_reg[3];
            pre_reg <= pre_next;
        end
        else if (cmd.round_en)
        begin
            a_reg   <= d_reg;
            b_reg   <= new_b;
            c_reg   <= b_reg;
            d_reg   <= c_reg;
            pre_reg <= pre_next;
        end
    end

    // chaining values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
                chain_reg[k] <= md5_pkg::INIT_VECTOR[k];
        end
        else if (cmd.init_chain)
        begin
            for (int k = 0; k < 4; k++)
                chain_reg[k] <= md5_pkg::INIT_VECTOR[k];
        end
        else if (cmd.add_chain)
        begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
        end
    end

    // digest item from the chaining registers
    assign digest.digest_word  = chain_reg[cmd.out_idx];
    assign digest.digest_index = cmd.out_idx;
    assign digest.digest_last  = (cmd.out_idx == md5_pkg::LAST_DIGEST);

endmodule

/* rtl/core/md5_block_compression_unit.sv */
// md5 block compression: one message word item per cycle while loading a block
// after the sixteenth word of a block: a setup step, 64 round steps, then an add step
// no new word is taken while a block is being compressed
// after a final block the four digest items follow the add step, one a cycle while digest_ready is high
// reset: controller to load state at word 0, chaining values to the initial vector;
// the block word store is not reset and is always written before it is read
module md5_block_compression_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    msg_valid,
    output logic                    msg_ready,
    input  md5_pkg::msg_item_t      msg,
    output logic                    digest_valid,
    input  logic                    digest_ready,
    output md5_pkg::digest_item_t   digest
);

    md5_pkg::md5_cmd_t cmd;

    // controller
    md5_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .first_block  (msg.first_block),
        .last_block   (msg.last_block),
        .msg_ready    (msg_ready),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .cmd          (cmd)
    );

    // datapath
    md5_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .msg_word (msg.msg_word),
        .digest   (digest)
    );

    // no item is taken while digest items are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> !msg_ready)
        else $error("item accepted during digest output");

    // the sixteenth word starts compression and blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        (msg_valid && msg_ready && cmd.load_idx == md5_pkg::LAST_WORD) |=> !msg_ready)
        else $error("input still open after block completed");

    // after the last digest item the block returns to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && digest_ready && digest.digest_last) |=> (msg_ready && !digest_valid))
        else $error("no return to loading after digest");

    // rounds and word loading never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round_en |-> (!cmd.load_en && !cmd.add_chain && !digest_valid))
        else $error("round overlaps another operation");

endmodule

/* tb/tb_md5_block_compression_unit.sv */
module tb_md5_block_compression_unit;

    // standard md5 additive constants, one per round
    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // left rotate amounts, four per round group
    localparam int MD5_SHIFT [16] = '{
        7, 12, 17, 22,
        5,  9, 14, 20,
        4, 11, 16, 23,
        6, 10, 15, 21
    };

    localparam logic [31:0] MD5_IV [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    // shapes of generated messages
    typedef enum int {
        KIND_NORMAL,
        KIND_NO_FIRST,
        KIND_RESTART,
        KIND_ODD_LAST
    } msg_kind_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     msg_valid = 1'b0;
    logic                     msg_ready;
    md5_pkg::msg_item_t       msg = '0;
    logic                     digest_valid;
    logic                     digest_ready = 1'b0;
    md5_pkg::digest_item_t    digest;

    // stimulus and scoreboard state
    md5_pkg::msg_item_t       word_queue [$];
    md5_pkg::digest_item_t    pending_digests [$];
    md5_pkg::digest_item_t    want;
    int                       words_queued = 0;
    int                       words_taken = 0;
    int                       planned_digests = 0;
    int                       send_idle_pct = 22;
    int                       recv_idle_pct = 81;
    int                       recv_hold_left = 0;
    int                       err_cnt = 0;

    // predictor state: chaining values, current block and word position
    logic [31:0]              chain_vals [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };
    logic [31:0]              blk_words [16];
    logic [3:0]               word_pos = 4'd0;

    md5_block_compression_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_ready    (msg_ready),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // fold one accepted word into the predicted hash state
    function automatic void absorb_word(input md5_pkg::msg_item_t it);
        logic [31:0]           a, b, c, d, f, t;
        int                    i, grp, g, s;
        md5_pkg::digest_item_t res;
        if (word_pos == 4'd0 && it.first_block)
            for (i = 0; i < 4; i++)
                chain_vals[i] = MD5_IV[i];
        blk_words[word_pos] = it.msg_word;
        if (word_pos == 4'd15)
        begin
            a = chain_vals[0];
            b = chain_vals[1];
            c = chain_vals[2];
            d = chain_vals[3];
            // 64 rounds in four groups of sixteen
            for (i = 0; i < 64; i++)
            begin
                grp = i / 16;
                case (grp)
                    0:
                    begin
                        f = (b & c) | (~b & d);
                        g = i;
                    end
                    1:
                    begin
                        f = (d & b) | (~d & c);
                        g = (5 * i + 1) % 16;
                    end
                    2:
                    begin
                        f = b ^ c ^ d;
                        g = (3 * i + 5) % 16;
                    end
                    default:
                    begin
                        f = c ^ (b | ~d);
                        g = (7 * i) % 16;
                    end
                endcase
                t = f + a + blk_words[g] + MD5_K[i];
                s = MD5_SHIFT[grp * 4 + i % 4];
                a = d;
                d = c;
                c = b;
                b = b + ((t << s) | (t >> (32 - s)));
            end
            chain_vals[0] = chain_vals[0] + a;
            chain_vals[1] = chain_vals[1] + b;
            chain_vals[2] = chain_vals[2] + c;
            chain_vals[3] = chain_vals[3] + d;
            // a final block releases the four digest words
            if (it.last_block)
                for (i = 0; i < 4; i++)
                begin
                    res.digest_word  = chain_vals[i];
                    res.digest_index = 2'(i);
                    res.digest_last  = (i == 3);
                    pending_digests.push_back(res);
                end
        end
        word_pos = word_pos + 4'd1;
    endfunction

    task automatic report_error(input string what);
        $display("mismatch at %0t: %s", $time, what);
        err_cnt++;
    endtask

    task automatic push_word(input logic [31:0] w, input logic fb, input logic lb);
        md5_pkg::msg_item_t it;
        it.msg_word    = w;
        it.first_block = fb;
        it.last_block  = lb;
        word_queue.push_back(it);
        words_queued++;
    endtask

    // queue one message of nblk blocks; flags off the checked words are noise
    task automatic gen_message(input int nblk, input msg_kind_t kind);
        int          blk, w;
        logic [31:0] word;
        logic        fb, lb;
        for (blk = 0; blk < nblk; blk++)
            for (w = 0; w < 16; w++)
            begin
                case ($urandom_range(15))
                    0:       word = 32'h0;
                    1:       word = 32'hffffffff;
                    default: word = $urandom;
                endcase
                fb = 1'($urandom_range(1));
                lb = 1'($urandom_range(1));
                if (w == 0)
                    fb = (blk == 0) ? (kind != KIND_NO_FIRST) : (kind == KIND_RESTART);
                if (w == 15)
                begin
                    if (blk == nblk - 1)
                        lb = (kind != KIND_ODD_LAST);
                    else
                        lb = (kind == KIND_ODD_LAST) && ($urandom_range(1) == 1);
                    if (lb)
                        planned_digests += 4;
                end
                push_word(word, fb, lb);
            end
    endtask

    // sender pauses until every item is taken and every digest has come
    task automatic wait_drained();
        while (words_taken != words_queued || pending_digests.size() != 0 ||
               recv_hold_left != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    // mostly well-formed messages, some with broken flags
    task automatic run_random(input int item_goal, input int digest_goal);
        int        start_items, start_digests, r, nblk;
        msg_kind_t kind;
        start_items   = words_queued;
        start_digests = planned_digests;
        while (words_queued - start_items < item_goal ||
               planned_digests - start_digests < digest_goal)
        begin
            r = $urandom_range(9);
            if (r < 7)
                kind = KIND_NORMAL;
            else if (r == 7)
                kind = KIND_NO_FIRST;
            else if (r == 8)
                kind = KIND_RESTART;
            else
                kind = KIND_ODD_LAST;
            nblk = ($urandom_range(3) == 0) ? $urandom_range(3, 2) : 1;
            if (kind == KIND_RESTART && nblk < 2)
                nblk = 2;
            gen_message(nblk, kind);
        end
        wait_drained();
    endtask

    // message word driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_valid <= 1'b0;
            msg       <= '0;
        end
        else
        begin
            if (msg_valid && msg_ready)
            begin
                absorb_word(msg);
                words_taken <= words_taken + 1;
            end
            if (!msg_valid || msg_ready)
            begin
                if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    msg_valid <= 1'b1;
                    msg       <= word_queue.pop_front();
                end
                else
                    msg_valid <= 1'b0;
            end
        end
    end

    // digest receiver with random stalls and an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            digest_ready <= 1'b0;
        else if (recv_hold_left > 0)
        begin
            digest_ready   <= 1'b0;
            recv_hold_left <= recv_hold_left - 1;
        end
        else
            digest_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // digest monitor, compared in order
    always @(posedge clk)
    begin
        if (rst_n && digest_valid && digest_ready)
        begin
            if (pending_digests.size() == 0)
                report_error($sformatf("digest item %h with none pending", digest));
            else
            begin
                want = pending_digests.pop_front();
                if (digest.digest_word !== want.digest_word)
                    report_error($sformatf("digest_word got %h want %h",
                                           digest.digest_word, want.digest_word));
                if (digest.digest_index !== want.digest_index)
                    report_error($sformatf("digest_index got %0d want %0d",
                                           digest.digest_index, want.digest_index));
                if (digest.digest_last !== want.digest_last)
                    report_error($sformatf("digest_last got %b want %b",
                                           digest.digest_last, want.digest_last));
            end
        end
    end

    // stimulus sequence
    initial
    begin
        int          k;
        logic [31:0] w;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed block: extreme words, noisy flags mid-block, final block
        for (k = 0; k < 16; k++)
        begin
            case (k % 4)
                0:       w = 32'h0;
                1:       w = 32'hffffffff;
                2:       w = 32'ha5a5a5a5;
                default: w = $urandom;
            endcase
            if (k == 0)
                push_word(w, 1'b1, 1'b0);
            else if (k == 15)
                push_word(w, 1'b1, 1'b1);
            else
                push_word(w, k[0], k[1]);
        end
        wait_drained();
        run_random(24, 4);

        // long receiver hold-off so the block backs up into its input
        send_idle_pct  = 0;
        recv_hold_left = 600;
        for (k = 0; k < 2; k++)
            gen_message(1, KIND_NORMAL);
        wait_drained();

        send_idle_pct = 81;
        recv_idle_pct = 22;
        run_random(24, 4);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(24, 4);

        if (err_cnt == 0)
            $display("tb_md5_block_compression_unit: clean");
        else
            $display("tb_md5_block_compression_unit: errors");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("tb_md5_block_compression_unit: errors");
        $finish;
    end

endmodule
